// ----- rtl/mpf_pkg.sv -----
// Shared types and constants of the monochrome page frame store.
// No dependencies; every other file in rtl/ except mpf_store imports this package.
package mpf_pkg;

	// Default geometry
	localparam int PANEL_WIDTH_DEF    = 128;
	localparam int MAX_PAGES_DEF      = 8;
	localparam int BYTES_PER_WORD_DEF = 8;
	localparam int SHORT_PAGES        = 4;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int X_W       = 7;
	localparam int Y_W       = 6;
	localparam int COLOUR_W  = 24;
	localparam int PAGE_W    = 3;
	localparam int KIND_W    = 3;
	localparam int PAYLOAD_W = 64;
	localparam int IN_DATA_W = 40;

	// Colour and controller constants
	localparam logic [COLOUR_W-1:0] COLOUR_MSBS = 24'h808080;
	localparam logic [COLOUR_W-1:0] FULL_COLOUR = 24'hFFFFFF;
	localparam logic [7:0]          PAGE_CMD    = 8'hB0;
	localparam logic [7:0]          COL_HI_CMD  = 8'h10;
	localparam logic [7:0]          COL_LO_CMD  = 8'h00;

	// Order of the command bytes of a flush
	localparam logic [1:0] CB_PAGE   = 2'd0;
	localparam logic [1:0] CB_COL_HI = 2'd1;
	localparam logic [1:0] CB_COL_LO = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ   = 3'd0,
		KIND_CMD    = 3'd1,
		KIND_DATA   = 3'd2,
		KIND_DONE   = 3'd3,
		KIND_REJECT = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PIX,
		ST_EMIT,
		ST_CLR,
		ST_CMD,
		ST_FRD,
		ST_FDAT
	} state_t;

	// One result beat handed from the sequencer to the output register
	typedef struct packed {
		kind_t                  kind;
		logic [PAYLOAD_W-1:0]   payload;
		logic                   last;
	} res_t;

endpackage

// ----- rtl/mono_page_framebuffer_flush_top.sv -----
// Top level of the monochrome page frame store with page flush.
// Depends on mpf_pkg, mpf_store, mpf_ctrl and mpf_out.
//
// Usage:
//   Input beats on s_* carry one command each: set pixel, read pixel,
//   clear store, or flush one page. Result beats leave on m_*; m_tuser
//   gives the kind, m_tlast marks the final beat of a command.
//   cfg_we/cfg_wdata write short_panel (1 = four pages of a 32-row panel).
// Command sequences:
//   Set and read pixel: the row read-modify-write of the
//   single-port-per-direction store is the critical loop.
//   Clear: zeroes active pages * ceil(PANEL_WIDTH / BYTES_PER_WORD) rows,
//   one store row per cycle.
//   Flush: 3 command beats, then per data word a read of the row and then
//   its presentation, ceil(PANEL_WIDTH/BYTES_PER_WORD) words.
//   A new command is taken only after the previous one has handed over
//   all of its result beats.
// Reset:
//   After arst_n releases, a clearing pass zeroes all
//   MAX_PAGES * ceil(PANEL_WIDTH / BYTES_PER_WORD) rows, one per cycle;
//   s_tready stays low meanwhile.
// Stalls:
//   A one-beat output register holds the pending result while m_tready is
//   low; the sequencer pauses on that beat and resumes without loss.
module mono_page_framebuffer_flush_top #(
	parameter int PANEL_WIDTH    = mpf_pkg::PANEL_WIDTH_DEF,
	parameter int MAX_PAGES      = mpf_pkg::MAX_PAGES_DEF,
	parameter int BYTES_PER_WORD = mpf_pkg::BYTES_PER_WORD_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// x_pos[6:0], y_pos[12:7], colour[36:13], page_index[39:37]
	input  logic [mpf_pkg::IN_DATA_W-1:0]     s_tdata,
	// command[1:0]
	input  logic [mpf_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// payload[63:0]
	output logic [mpf_pkg::PAYLOAD_W-1:0]     m_tdata,
	// out_kind[2:0]
	output logic [mpf_pkg::KIND_W-1:0]        m_tuser,
	output logic                              m_tlast
);
	import mpf_pkg::*;

	localparam int WPP   = (PANEL_WIDTH + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
	localparam int DEPTH = MAX_PAGES * WPP;
	localparam int RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = BYTES_PER_WORD * 8;

	logic           mem_re, mem_we;
	logic [RAW-1:0] mem_raddr, mem_waddr;
	logic [DW-1:0]  mem_wdata, mem_rdata;
	logic           push, slot_free;
	res_t           res;

	// Row store
	mpf_store #(
		.DEPTH (DEPTH),
		.DW    (DW),
		.AW    (RAW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Command sequencer
	mpf_ctrl #(
		.PANEL_WIDTH    (PANEL_WIDTH),
		.MAX_PAGES      (MAX_PAGES),
		.BYTES_PER_WORD (BYTES_PER_WORD)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cmd        (s_tuser),
		.x_pos      (s_tdata[6:0]),
		.y_pos      (s_tdata[12:7]),
		.colour     (s_tdata[36:13]),
		.page_index (s_tdata[39:37]),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.slot_free  (slot_free),
		.push       (push),
		.res        (res)
	);

	// Result register toward the sink
	mpf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- rtl/mpf_store.sv -----
// Frame store memory: one write port, one read port, registered read data.
// Rows are BYTES_PER_WORD column bytes of one page. Depends on nothing.
module mpf_store #(
	parameter int DEPTH = 128,
	parameter int DW    = 64,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write one row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one row, hold the data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/mpf_out.sv -----
// Output register of the result stream: holds one beat while the sink stalls.
// Depends on mpf_pkg for the result beat type.
module mpf_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mpf_pkg::res_t              res,
	output logic                       slot_free,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [mpf_pkg::PAYLOAD_W-1:0] m_tdata,
	output logic [mpf_pkg::KIND_W-1:0] m_tuser,
	output logic                       m_tlast
);
	import mpf_pkg::*;

	logic valid_q;
	res_t res_q;

	assign slot_free = !valid_q || m_tready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the beat
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.payload;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

endmodule

// ----- rtl/mpf_ctrl.sv -----
// Command sequencer: decodes commands, does the read-modify-write of store
// rows, walks the store for the reset pass, clear and flush. Depends on mpf_pkg.
module mpf_ctrl #(
	parameter int PANEL_WIDTH    = 128,
	parameter int MAX_PAGES      = 8,
	parameter int BYTES_PER_WORD = 8,
	localparam int WPP   = (PANEL_WIDTH + BYTES_PER_WORD - 1) / BYTES_PER_WORD,
	localparam int DEPTH = MAX_PAGES * WPP,
	localparam int RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int DW    = BYTES_PER_WORD * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mpf_pkg::CMD_W-1:0]     cmd,
	input  logic [mpf_pkg::X_W-1:0]       x_pos,
	input  logic [mpf_pkg::Y_W-1:0]       y_pos,
	input  logic [mpf_pkg::COLOUR_W-1:0]  colour,
	input  logic [mpf_pkg::PAGE_W-1:0]    page_index,
	output logic                          mem_re,
	output logic [RAW-1:0]                mem_raddr,
	output logic                          mem_we,
	output logic [RAW-1:0]                mem_waddr,
	output logic [DW-1:0]                 mem_wdata,
	input  logic [DW-1:0]                 mem_rdata,
	input  logic                          slot_free,
	output logic                          push,
	output mpf_pkg::res_t                 res
);
	import mpf_pkg::*;

	localparam int XN   = 2 ** X_W;
	localparam int WAW  = (WPP > 1) ? $clog2(WPP) : 1;
	localparam int LW   = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
	localparam int BW   = $clog2(DW);
	localparam int WW   = (WPP > 1) ? $clog2(WPP) : 1;
	localparam int SHORT_N = (MAX_PAGES < SHORT_PAGES) ? MAX_PAGES : SHORT_PAGES;

	state_t state_q, state_d;
	logic   short_q;
	kind_t  kind_q;
	logic [RAW-1:0] row_q;
	logic [BW-1:0]  bitpos_q;
	logic           set_on_q;
	logic           is_set_q;
	logic [PAGE_W-1:0] page_q;
	logic [RAW-1:0] base_q;
	logic [RAW:0]   cnt_q;
	logic [WW:0]    wcnt_q;
	logic [1:0]     ccnt_q;

	logic [WAW-1:0] word_tbl [XN];
	logic [LW-1:0]  lane_tbl [XN];

	cmd_t     cmd_c;
	logic     accept;
	logic [4:0] act_pages;
	logic [RAW:0] clr_end;
	logic     pix_ok, flush_ok;
	logic     dither_off, set_on;
	logic [RAW-1:0] acc_row;
	logic [BW-1:0]  acc_bitpos;
	logic [DW-1:0]  mask;
	logic     wlast;
	logic     cnt_end_init, cnt_end_clr;

	// Column to row word and byte lane, fixed at elaboration
	for (genvar gi = 0; gi < XN; gi++) begin : g_col
		assign word_tbl[gi] = WAW'(gi / BYTES_PER_WORD);
		assign lane_tbl[gi] = LW'(gi % BYTES_PER_WORD);
	end

	// Decode the incoming beat
	assign cmd_c     = cmd_t'(cmd);
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign act_pages = short_q ? 5'(SHORT_N) : 5'(MAX_PAGES);
	assign clr_end   = short_q ? (RAW+1)'(SHORT_N * WPP) : (RAW+1)'(DEPTH);
	assign pix_ok    = ({2'b00, x_pos} < 9'(PANEL_WIDTH))
		&& ({2'b00, y_pos[5:3]} < act_pages);
	assign flush_ok  = ({2'b00, page_index} < act_pages);
	assign acc_row   = RAW'(int'(y_pos[5:3]) * WPP + int'(word_tbl[x_pos]));
	assign acc_bitpos = BW'({lane_tbl[x_pos], y_pos[2:0]});
	assign dither_off = (colour != '0) && ((colour & COLOUR_MSBS) == '0)
		&& (x_pos[0] ^ y_pos[0]);
	assign set_on    = (colour != '0) && !dither_off;

	assign mask  = DW'(1) << bitpos_q;
	assign wlast = (wcnt_q == (WW+1)'(WPP - 1));
	assign cnt_end_init = ((cnt_q + 1'b1) == (RAW+1)'(DEPTH));
	assign cnt_end_clr  = ((cnt_q + 1'b1) == clr_end);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (cnt_end_init) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_c)
						CMD_SET, CMD_READ: state_d = pix_ok ? ST_PIX : ST_EMIT;
						CMD_CLEAR:         state_d = ST_CLR;
						CMD_FLUSH:         state_d = flush_ok ? ST_CMD : ST_EMIT;
					endcase
				end
			end
			ST_PIX, ST_EMIT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_CLR: begin
				if (cnt_end_clr) state_d = ST_EMIT;
			end
			ST_CMD: begin
				if (slot_free && ccnt_q == CB_COL_LO) state_d = ST_FRD;
			end
			ST_FRD: state_d = ST_FDAT;
			ST_FDAT: begin
				if (slot_free) state_d = wlast ? ST_IDLE : ST_FRD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory accesses and result beats
	always_comb begin
		mem_re      = 1'b0;
		mem_raddr   = acc_row;
		mem_we      = 1'b0;
		mem_waddr   = cnt_q[RAW-1:0];
		mem_wdata   = '0;
		push        = 1'b0;
		res.kind    = kind_q;
		res.payload = '0;
		res.last    = 1'b1;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_re = in_valid && (cmd_c == CMD_SET || cmd_c == CMD_READ);
			end
			ST_PIX: begin
				push      = slot_free;
				mem_we    = is_set_q && slot_free;
				mem_waddr = row_q;
				mem_wdata = set_on_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
				if (is_set_q) begin
					res.kind = KIND_DONE;
				end else begin
					res.kind = KIND_READ;
					if ((mem_rdata & mask) != '0) res.payload = PAYLOAD_W'(FULL_COLOUR);
				end
			end
			ST_EMIT: begin
				push = slot_free;
			end
			ST_CMD: begin
				push     = slot_free;
				res.kind = KIND_CMD;
				res.last = 1'b0;
				case (ccnt_q)
					CB_PAGE:   res.payload = PAYLOAD_W'(PAGE_CMD | {5'b00000, page_q});
					CB_COL_HI: res.payload = PAYLOAD_W'(COL_HI_CMD);
					default:   res.payload = PAYLOAD_W'(COL_LO_CMD);
				endcase
			end
			ST_FRD: begin
				mem_re    = 1'b1;
				mem_raddr = base_q + RAW'(wcnt_q);
			end
			ST_FDAT: begin
				push        = slot_free;
				res.kind    = KIND_DATA;
				res.payload = PAYLOAD_W'(mem_rdata);
				res.last    = wlast;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			short_q <= 1'b0;
			cnt_q   <= '0;
			wcnt_q  <= '0;
			ccnt_q  <= CB_PAGE;
		end else begin
			state_q <= state_d;
			if (cfg_we) short_q <= cfg_wdata;
			// Sweep counter for the reset pass and for clear
			if (state_q == ST_INIT || state_q == ST_CLR) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			// Command byte and data word counters of a flush
			if (state_q == ST_CMD) begin
				if (slot_free) ccnt_q <= ccnt_q + 1'b1;
			end else begin
				ccnt_q <= CB_PAGE;
			end
			if (state_q == ST_FDAT) begin
				if (slot_free) wcnt_q <= wcnt_q + 1'b1;
			end else if (state_q == ST_IDLE) begin
				wcnt_q <= '0;
			end
		end
	end

	// Latch the fields of an accepted command
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= acc_row;
			bitpos_q <= acc_bitpos;
			set_on_q <= set_on;
			is_set_q <= (cmd_c == CMD_SET);
			page_q   <= page_index;
			base_q   <= RAW'(int'(page_index) * WPP);
			kind_q   <= (cmd_c == CMD_CLEAR) ? KIND_DONE : KIND_REJECT;
		end
	end

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free) else $error("result pushed into a full output register");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_INIT || state_q == ST_PIX || state_q == ST_CLR))
		else $error("store written outside a write state");

	a_pix_next: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd_c == CMD_SET || cmd_c == CMD_READ) && pix_ok)
		|=> (state_q == ST_PIX && $past(mem_re)))
		else $error("pixel command without a row read");

	a_wcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRD) |-> (wcnt_q < (WW+1)'(WPP)))
		else $error("flush word counter past the page");

endmodule

// ----- sim/tb_mono_page_framebuffer_flush_top.sv -----
// Self-checking testbench for mono_page_framebuffer_flush_top: a scoreboard class predicts
// result beats from each accepted command and compares them field by field.
// Depends on rtl/mpf_pkg.sv and the RTL of the top level and its submodules.
module tb_mono_page_framebuffer_flush_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mpf_pkg::*;

	localparam int STORE_BYTES    = PANEL_WIDTH_DEF * MAX_PAGES_DEF;
	localparam int WORDS_PER_PAGE = (PANEL_WIDTH_DEF + BYTES_PER_WORD_DEF - 1) / BYTES_PER_WORD_DEF;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 40;

	// Frame store predictor and queue of expected result beats
	class flush_scoreboard;
		logic [7:0] frame_bytes [STORE_BYTES];
		bit         short_mode;
		res_t       expected_beats[$];
		int         errors;

		function new();
			foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
			short_mode = 1'b0;
			errors = 0;
		endfunction

		function void set_short(bit v);
			short_mode = v;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void add_beat(kind_t k, logic [PAYLOAD_W-1:0] p, logic l);
			res_t r;
			r.kind = k;
			r.payload = p;
			r.last = l;
			expected_beats.push_back(r);
		endfunction

		// Apply one accepted command to the store and queue its result beats
		function void note_command(cmd_t cmd, logic [X_W-1:0] x, logic [Y_W-1:0] y,
				logic [COLOUR_W-1:0] colour, logic [PAGE_W-1:0] page);
			int pages;
			int idx;
			int base;
			int col;
			logic [7:0] mask;
			logic [PAYLOAD_W-1:0] word;
			logic [COLOUR_W-1:0] c;
			pages = short_mode ? SHORT_PAGES : MAX_PAGES_DEF;
			case (cmd)
				CMD_SET, CMD_READ: begin
					if (int'(x) >= PANEL_WIDTH_DEF || int'(y[5:3]) >= pages) begin
						add_beat(KIND_REJECT, '0, 1'b1);
						return;
					end
					idx = int'(y[5:3]) * PANEL_WIDTH_DEF + int'(x);
					mask = 8'h01 << y[2:0];
					if (cmd == CMD_READ) begin
						add_beat(KIND_READ,
							((frame_bytes[idx] & mask) != 0) ? 64'(FULL_COLOUR) : 64'h0, 1'b1);
						return;
					end
					// dim colours dither off on odd x+y
					c = colour;
					if (c != 0 && (c & COLOUR_MSBS) == 0 && (x[0] ^ y[0]))
						c = '0;
					if (c != 0)
						frame_bytes[idx] = frame_bytes[idx] | mask;
					else
						frame_bytes[idx] = frame_bytes[idx] & ~mask;
					add_beat(KIND_DONE, '0, 1'b1);
				end
				CMD_CLEAR: begin
					for (int i = 0; i < pages * PANEL_WIDTH_DEF; i++)
						frame_bytes[i] = 8'h00;
					add_beat(KIND_DONE, '0, 1'b1);
				end
				default: begin
					if (int'(page) >= pages) begin
						add_beat(KIND_REJECT, '0, 1'b1);
						return;
					end
					base = int'(page) * PANEL_WIDTH_DEF;
					add_beat(KIND_CMD, 64'(PAGE_CMD | {5'b0, page}), 1'b0);
					add_beat(KIND_CMD, 64'(COL_HI_CMD), 1'b0);
					add_beat(KIND_CMD, 64'(COL_LO_CMD), 1'b0);
					for (int w = 0; w < WORDS_PER_PAGE; w++) begin
						word = '0;
						for (int b = 0; b < BYTES_PER_WORD_DEF; b++) begin
							col = w * BYTES_PER_WORD_DEF + b;
							if (col < PANEL_WIDTH_DEF)
								word = word | (64'(frame_bytes[base + col]) << (8 * b));
						end
						add_beat(KIND_DATA, word, (w == WORDS_PER_PAGE - 1));
					end
				end
			endcase
		endfunction

		// Compare one accepted result beat with the oldest expectation
		function void check_beat(logic [KIND_W-1:0] kind, logic [PAYLOAD_W-1:0] payload,
				logic last);
			res_t want;
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, actual kind %0d payload %h last %b",
					$time, kind, payload, last);
				return;
			end
			want = expected_beats.pop_front();
			if (kind !== want.kind) begin
				errors++;
				$display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, kind);
			end
			if (payload !== want.payload) begin
				errors++;
				$display("%0t: payload mismatch: expected %h actual %h", $time, want.payload,
					payload);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last mismatch: expected %b actual %b", $time, want.last, last);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata   = '0;
	logic [CMD_W-1:0]     s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [PAYLOAD_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	flush_scoreboard sb;
	bit idling_on     = 1'b1;
	bit long_hold_req = 1'b0;
	int cycle_count   = 0;

	mono_page_framebuffer_flush_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a run that hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: check each beat, stall in random bursts or one long hold
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_beat(m_tuser, m_tdata, m_tlast);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one command beat and hold it until accepted
	task automatic send_cmd(cmd_t cmd, logic [X_W-1:0] x, logic [Y_W-1:0] y,
			logic [COLOUR_W-1:0] colour, logic [PAGE_W-1:0] page);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {page, colour, y, x};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, x, y, colour, page);
	endtask

	// Drain all results, then write the panel height register
	task automatic write_panel_mode(bit v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_short(v);
	endtask

	// Random commands; coordinates often cluster so reads hit written pixels
	task automatic run_random(int count);
		cmd_t cmd;
		int n;
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [COLOUR_W-1:0] colour;
		logic [PAGE_W-1:0] page;
		for (int i = 0; i < count; i++) begin
			n = $urandom_range(0, 99);
			if (n < 45)
				cmd = CMD_SET;
			else if (n < 70)
				cmd = CMD_READ;
			else if (n < 74)
				cmd = CMD_CLEAR;
			else
				cmd = CMD_FLUSH;
			if ($urandom_range(0, 1) == 0) begin
				x = X_W'($urandom_range(0, 15));
				y = Y_W'($urandom_range(0, 15));
			end else begin
				x = X_W'($urandom_range(0, 127));
				if (sb.short_mode && $urandom_range(0, 9) != 0)
					y = Y_W'($urandom_range(0, 31));
				else
					y = Y_W'($urandom_range(0, 63));
			end
			case ($urandom_range(0, 3))
				0: colour = '0;
				1: begin
					colour = COLOUR_W'($urandom) & 24'h7F7F7F;
					if (colour == 0)
						colour = 24'h010000;
				end
				2: colour = COLOUR_W'($urandom) | (24'h000080 << (8 * $urandom_range(0, 2)));
				default: colour = COLOUR_W'($urandom);
			endcase
			if (sb.short_mode && $urandom_range(0, 6) != 0)
				page = PAGE_W'($urandom_range(0, 3));
			else
				page = PAGE_W'($urandom_range(0, 7));
			send_cmd(cmd, x, y, colour, page);
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing pass after reset
		while (!s_tready) @(posedge clk);
		write_panel_mode(1'b0);

		// Directed: extremes, dithering, readback, flush, clear
		send_cmd(CMD_SET, 7'd0, 6'd0, 24'hFFFFFF, 3'd0);
		send_cmd(CMD_SET, 7'd127, 6'd63, 24'h808080, 3'd7);
		send_cmd(CMD_SET, 7'd1, 6'd0, 24'h7F7F7F, 3'd0);
		send_cmd(CMD_SET, 7'd2, 6'd0, 24'h010101, 3'd0);
		send_cmd(CMD_SET, 7'd3, 6'd0, 24'h800000, 3'd0);
		send_cmd(CMD_READ, 7'd0, 6'd0, 24'h000000, 3'd0);
		send_cmd(CMD_READ, 7'd1, 6'd0, 24'hFFFFFF, 3'd7);
		send_cmd(CMD_READ, 7'd127, 6'd63, 24'h000000, 3'd0);
		send_cmd(CMD_FLUSH, 7'd0, 6'd0, 24'h000000, 3'd0);
		send_cmd(CMD_FLUSH, 7'd127, 6'd63, 24'hFFFFFF, 3'd7);
		send_cmd(CMD_SET, 7'd0, 6'd0, 24'h000000, 3'd0);
		send_cmd(CMD_READ, 7'd0, 6'd0, 24'h000000, 3'd0);
		send_cmd(CMD_CLEAR, 7'd127, 6'd63, 24'hFFFFFF, 3'd7);
		send_cmd(CMD_READ, 7'd2, 6'd0, 24'h000000, 3'd0);
		send_cmd(CMD_SET, 7'd127, 6'd63, 24'hFFFFFF, 3'd0);

		// Short panel: out-of-range rows and pages, clear keeps upper pages
		write_panel_mode(1'b1);
		send_cmd(CMD_SET, 7'd5, 6'd32, 24'hFFFFFF, 3'd0);
		send_cmd(CMD_READ, 7'd0, 6'd63, 24'h000000, 3'd0);
		send_cmd(CMD_FLUSH, 7'd0, 6'd0, 24'h000000, 3'd4);
		send_cmd(CMD_FLUSH, 7'd0, 6'd0, 24'h000000, 3'd7);
		send_cmd(CMD_SET, 7'd127, 6'd31, 24'hFFFFFF, 3'd0);
		send_cmd(CMD_FLUSH, 7'd0, 6'd0, 24'h000000, 3'd3);
		send_cmd(CMD_CLEAR, 7'd0, 6'd0, 24'h000000, 3'd0);
		send_cmd(CMD_FLUSH, 7'd0, 6'd0, 24'h000000, 3'd3);
		write_panel_mode(1'b0);
		send_cmd(CMD_FLUSH, 7'd0, 6'd0, 24'h000000, 3'd7);

		// Random phases; the first one backs up the block with a long output hold
		long_hold_req = 1'b1;
		run_random(100);
		write_panel_mode(1'b1);
		run_random(100);
		write_panel_mode(1'b0);
		run_random(80);
		write_panel_mode(1'b1);
		idling_on = 1'b0;
		run_random(100);

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mpf_pkg.sv
rtl/mpf_store.sv
rtl/mpf_out.sv
rtl/mpf_ctrl.sv
rtl/mono_page_framebuffer_flush_top.sv
sim/tb_mono_page_framebuffer_flush_top.sv
